### rtl/vrt_pkg.sv
`default_nettype none
package vrt_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;
  localparam int MAX_STEPS   = 100;

  localparam int XZ_W    = $clog2(GRID_WIDTH);
  localparam int Y_W     = $clog2(GRID_HEIGHT);
  localparam int ROW_AW  = Y_W + XZ_W;
  localparam int ROW_CNT = 1 << ROW_AW;
  localparam int STEPS_W = $clog2(MAX_STEPS + 1);
  localparam int CELL_W  = 16 + STEPS_W + 1;
  localparam int T_W     = 44;
  localparam int QUO_W   = 31;
  localparam int DIVR_W  = 16;
  localparam int DIV_CNT_W = $clog2(QUO_W + 1);

  localparam logic [2:0] FACE_START = 3'd6;
  localparam logic [2:0] DIV_LAST   = 3'd5;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SET_RD, ST_SET_WR,
    ST_DIV_GO, ST_DIV_WAIT, ST_WALK_RD, ST_WALK_EV
  } vrt_state_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic set_rd;
    logic set_wr;
    logic div_go;
    logic div_store;
    logic walk_rd;
    logic step;
    logic out_hit;
    logic out_miss;
  } vrt_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic div_last;
    logic solid;
    logic never_sel;
    logic over_limit;
    logic steps_last;
  } vrt_stat_t;

endpackage
`default_nettype wire

### rtl/vrt_ram.sv
`default_nettype none
module vrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one word, register the read word
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/vrt_div.sv
`default_nettype none
module vrt_div
  import vrt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire logic [QUO_W-1:0]  dividend,
  input  wire logic [DIVR_W-1:0] divisor,
  output logic                   done,
  output logic      [QUO_W-1:0]  quo
);

  logic                 run_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIVR_W-1:0]    rem_r, div_r;
  logic [QUO_W-1:0]     quo_r;
  logic [DIVR_W:0]      rem_sh;
  logic                 fits;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh = {rem_r, quo_r[QUO_W-1]};
    fits   = rem_sh >= {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(QUO_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      div_r <= divisor;
      quo_r <= dividend;
    end else if (run_r) begin
      rem_r <= fits ? DIVR_W'(rem_sh - {1'b0, div_r}) : rem_sh[DIVR_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

### rtl/vrt_ctrl.sv
`default_nettype none
module vrt_ctrl
  import vrt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire logic      kind,
  input  wire vrt_stat_t stat,
  output vrt_cmd_t       cmd,
  output logic           busy
);

  vrt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  // sequence clear, set, divide and walk
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = kind ? ST_DIV_GO : ST_SET_RD;
        end
      end
      ST_SET_RD: begin
        cmd.set_rd = 1'b1;
        state_nxt  = ST_SET_WR;
      end
      ST_SET_WR: begin
        cmd.set_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_DIV_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = stat.div_last ? ST_WALK_RD : ST_DIV_GO;
        end
      end
      ST_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = ST_WALK_EV;
      end
      ST_WALK_EV: begin
        if (stat.solid) begin
          cmd.out_hit = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (stat.never_sel) begin
          cmd.out_miss = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
          if (stat.over_limit || stat.steps_last) begin
            cmd.out_miss = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_WALK_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = state_r != ST_IDLE;

endmodule
`default_nettype wire

### rtl/vrt_dp.sv
`default_nettype none
module vrt_dp
  import vrt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire vrt_cmd_t            cmd,
  output vrt_stat_t                stat,
  input  wire logic        [5:0]   voxel_x,
  input  wire logic        [5:0]   voxel_y,
  input  wire logic        [5:0]   voxel_z,
  input  wire logic                solid_flag,
  input  wire logic signed [23:0]  origin_x,
  input  wire logic signed [23:0]  origin_y,
  input  wire logic signed [23:0]  origin_z,
  input  wire logic signed [15:0]  dir_x,
  input  wire logic signed [15:0]  dir_y,
  input  wire logic signed [15:0]  dir_z,
  input  wire logic        [23:0]  max_distance,
  output logic                     out_valid,
  output logic                     out_hit,
  output logic signed      [15:0]  out_hit_x,
  output logic signed      [15:0]  out_hit_y,
  output logic signed      [15:0]  out_hit_z,
  output logic             [2:0]   out_hit_face
);

  logic signed [23:0] org [3];
  logic signed [15:0] dir [3];

  logic [5:0]              vx_r, vy_r, vz_r;
  logic                    sflag_r;
  logic signed [CELL_W-1:0] cell_r [3];
  logic                    pos_r [3];
  logic                    never_r [3];
  logic [DIVR_W-1:0]       ad_r [3];
  logic [8:0]              num_r [3];
  logic [T_W-1:0]          nt_r [3];
  logic [QUO_W-1:0]        delta_r [3];
  logic [31:0]             limit_r;
  logic [2:0]              face_r;
  logic [STEPS_W-1:0]      count_r;
  logic [2:0]              div_idx_r;
  logic [ROW_AW-1:0]       clr_r;
  logic [1:0]              sel_r;
  logic                    in_grid_r;
  logic [XZ_W-1:0]         bit_r;
  logic [ROW_AW-1:0]       row_r;
  logic                    valid_r, hit_r;
  logic [15:0]             hx_r, hy_r, hz_r;
  logic [2:0]              hf_r;

  logic [1:0]              dax;
  logic [QUO_W-1:0]        dividend;
  logic                    div_done;
  logic [QUO_W-1:0]        quo;
  logic                    lt01, lt02, lt12;
  logic [1:0]              sel;
  logic                    walk_in;
  logic                    set_in;
  logic [ROW_AW-1:0]       raddr, waddr;
  logic [GRID_WIDTH-1:0]   rdata, wdata, row_mod;
  logic                    we;

  assign org = '{origin_x, origin_y, origin_z};
  assign dir = '{dir_x, dir_y, dir_z};

  // capture the transaction and set up each axis, then step the cell of the chosen axis
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx_r    <= voxel_x;
      vy_r    <= voxel_y;
      vz_r    <= voxel_z;
      sflag_r <= solid_flag;
      limit_r <= {max_distance, 8'd0};
      for (int k = 0; k < 3; k++) begin
        cell_r[k]  <= CELL_W'($signed(org[k][23:8]));
        pos_r[k]   <= dir[k] > 16'sd0;
        never_r[k] <= dir[k] == 16'sd0;
        ad_r[k]    <= dir[k][15] ? DIVR_W'(-dir[k]) : DIVR_W'(dir[k]);
        num_r[k]   <= (dir[k] > 16'sd0) ? 9'(9'd256 - {1'b0, org[k][7:0]})
                                        : {1'b0, org[k][7:0]};
      end
    end else if (cmd.step) begin
      cell_r[sel_r] <= pos_r[sel_r] ? cell_r[sel_r] + CELL_W'(1)
                                    : cell_r[sel_r] - CELL_W'(1);
    end
  end

  // run six divisions: delta then first boundary, per axis
  assign dax      = div_idx_r[2:1];
  assign dividend = div_idx_r[0] ? {num_r[dax], 22'd0} : QUO_W'(1 << 30);

  vrt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (dividend),
    .divisor  (ad_r[dax]),
    .done     (div_done),
    .quo      (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      if (div_idx_r[0]) nt_r[dax]    <= T_W'(quo);
      else              delta_r[dax] <= quo;
    end else if (cmd.step) begin
      nt_r[sel_r] <= nt_r[sel_r] + T_W'(delta_r[sel_r]);
    end
  end

  // pick the axis with the nearest boundary; on a tie the higher-numbered axis wins
  always_comb begin
    lt01 = !never_r[0] && (never_r[1] || nt_r[0] < nt_r[1]);
    lt02 = !never_r[0] && (never_r[2] || nt_r[0] < nt_r[2]);
    lt12 = !never_r[1] && (never_r[2] || nt_r[1] < nt_r[2]);
    if (lt01) sel = lt02 ? 2'd0 : 2'd2;
    else      sel = lt12 ? 2'd1 : 2'd2;
  end

  assign walk_in = (cell_r[0] >= 0) && (cell_r[0] < CELL_W'(GRID_WIDTH))
                && (cell_r[1] >= 0) && (cell_r[1] < CELL_W'(GRID_HEIGHT))
                && (cell_r[2] >= 0) && (cell_r[2] < CELL_W'(GRID_WIDTH));
  assign set_in  = ({1'b0, vx_r} < 7'(GRID_WIDTH)) && ({1'b0, vy_r} < 7'(GRID_HEIGHT))
                && ({1'b0, vz_r} < 7'(GRID_WIDTH));

  // grid row address and bit for the walk or the set
  always_comb begin
    if (cmd.set_rd)
      raddr = {vy_r[Y_W-1:0], vz_r[XZ_W-1:0]};
    else
      raddr = {cell_r[1][Y_W-1:0], cell_r[2][XZ_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_rd) begin
      sel_r     <= sel;
      in_grid_r <= walk_in;
      bit_r     <= cell_r[0][XZ_W-1:0];
    end else if (cmd.set_rd) begin
      in_grid_r <= set_in;
      bit_r     <= vx_r[XZ_W-1:0];
    end
    row_r <= raddr;
  end

  // modify one bit of the row, or clear rows after reset
  always_comb begin
    row_mod        = rdata;
    row_mod[bit_r] = sflag_r;
  end

  assign we    = cmd.clr_wr || (cmd.set_wr && in_grid_r);
  assign waddr = cmd.clr_wr ? clr_r : row_r;
  assign wdata = cmd.clr_wr ? '0 : row_mod;

  vrt_ram #(.WIDTH(GRID_WIDTH), .DEPTH(ROW_CNT)) u_grid (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= '0;
      div_idx_r <= '0;
      count_r   <= '0;
      face_r    <= FACE_START;
      valid_r   <= 1'b0;
    end else begin
      valid_r <= cmd.out_hit || cmd.out_miss;
      if (cmd.clr_wr) clr_r <= clr_r + 1'b1;
      if (cmd.load) begin
        div_idx_r <= '0;
        count_r   <= '0;
        face_r    <= FACE_START;
      end else begin
        if (cmd.div_store) div_idx_r <= div_idx_r + 3'd1;
        if (cmd.step) begin
          count_r <= count_r + 1'b1;
          face_r  <= {sel_r, pos_r[sel_r]};
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.out_hit) begin
      hit_r <= 1'b1;
      hx_r  <= cell_r[0][15:0];
      hy_r  <= cell_r[1][15:0];
      hz_r  <= cell_r[2][15:0];
      hf_r  <= face_r;
    end else if (cmd.out_miss) begin
      hit_r <= 1'b0;
      hx_r  <= '0;
      hy_r  <= '0;
      hz_r  <= '0;
      hf_r  <= '0;
    end
  end

  always_comb begin
    stat            = '0;
    stat.clr_last   = clr_r == '1;
    stat.div_done   = div_done;
    stat.div_last   = div_idx_r == DIV_LAST;
    stat.solid      = in_grid_r && rdata[bit_r];
    stat.never_sel  = never_r[sel_r];
    stat.over_limit = nt_r[sel_r] > T_W'(limit_r);
    stat.steps_last = count_r == STEPS_W'(MAX_STEPS - 1);
  end

  assign out_valid    = valid_r;
  assign out_hit      = hit_r;
  assign out_hit_x    = hx_r;
  assign out_hit_y    = hy_r;
  assign out_hit_z    = hz_r;
  assign out_hit_face = hf_r;

endmodule
`default_nettype wire

### rtl/voxel_ray_traversal_core.sv
// Channel   Handshake             Ports
// ------    --------------------  ------------------------------------------
// input     start & !busy         in_kind, in_voxel_*, in_solid_flag,
//                                 in_origin_*, in_dir_*, in_max_distance
// result    out_valid, 1 cycle    out_hit, out_hit_x/y/z, out_hit_face
//
// A set transaction reads the grid row, then writes it back. A cast keeps
// busy high through six divisions at setup (launch, 31 radix-2 iterations,
// store), then a grid read and a decision per voxel check, up to 100 checks.
// After reset a clearing pass writes all 4096 grid rows with busy high. The
// result strobe cannot be stalled; it is given in the first cycle with busy
// low after a cast, and none is given for a set.
`default_nettype none
module voxel_ray_traversal_core
  import vrt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_kind,
  input  wire logic        [5:0]  in_voxel_x,
  input  wire logic        [5:0]  in_voxel_y,
  input  wire logic        [5:0]  in_voxel_z,
  input  wire logic               in_solid_flag,
  input  wire logic signed [23:0] in_origin_x,
  input  wire logic signed [23:0] in_origin_y,
  input  wire logic signed [23:0] in_origin_z,
  input  wire logic signed [15:0] in_dir_x,
  input  wire logic signed [15:0] in_dir_y,
  input  wire logic signed [15:0] in_dir_z,
  input  wire logic        [23:0] in_max_distance,
  output logic                    out_valid,
  output logic                    out_hit,
  output logic signed      [15:0] out_hit_x,
  output logic signed      [15:0] out_hit_y,
  output logic signed      [15:0] out_hit_z,
  output logic             [2:0]  out_hit_face
);

  vrt_cmd_t  cmd;
  vrt_stat_t stat;

  vrt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  vrt_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .voxel_x      (in_voxel_x),
    .voxel_y      (in_voxel_y),
    .voxel_z      (in_voxel_z),
    .solid_flag   (in_solid_flag),
    .origin_x     (in_origin_x),
    .origin_y     (in_origin_y),
    .origin_z     (in_origin_z),
    .dir_x        (in_dir_x),
    .dir_y        (in_dir_y),
    .dir_z        (in_dir_z),
    .max_distance (in_max_distance),
    .out_valid    (out_valid),
    .out_hit      (out_hit),
    .out_hit_x    (out_hit_x),
    .out_hit_y    (out_hit_y),
    .out_hit_z    (out_hit_z),
    .out_hit_face (out_hit_face)
  );

`ifndef SYNTHESIS
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without a transaction");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted transaction did not raise busy");
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_face == 3'd0 && out_hit_x == 16'sd0)
    else $error("miss result carries nonzero fields");
`endif

endmodule
`default_nettype wire
